### rtl/ocp_pkg.sv
// Shared types and constants for the outline point to cubic path converter.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package ocp_pkg;

	localparam int COORD_WIDTH = 24;
	// 2*c + p needs two extra bits, its magnitude one
	localparam int NUM_WIDTH = COORD_WIDTH + 2;
	localparam int MAG_WIDTH = COORD_WIDTH + 1;

	// floor(m/3) = (m * DIV_MUL) >> DIV_SHIFT, exact while 2*m < 2**DIV_SHIFT
	localparam int DIV_SHIFT = COORD_WIDTH + 2 + (COORD_WIDTH % 2);
	localparam logic [63:0] DIV_MUL_FULL = ((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3;
	localparam logic [DIV_SHIFT-2:0] DIV_MUL = DIV_MUL_FULL[DIV_SHIFT-2:0];

	localparam logic [1:0] CMD_MOVE  = 2'd0;
	localparam logic [1:0] CMD_LINE  = 2'd1;
	localparam logic [1:0] CMD_CUBIC = 2'd2;
	localparam logic [1:0] CMD_CLOSE = 2'd3;

	// point kinds; bit 0 set means on-curve
	localparam logic [1:0] KIND_QUAD  = 2'd0;
	localparam logic [1:0] KIND_CUBIC = 2'd2;

	// pending point count, pen included
	localparam logic [1:0] PEND_PEN = 2'd1;
	localparam logic [1:0] PEND_ONE = 2'd2;
	localparam logic [1:0] PEND_TWO = 2'd3;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	// one output coordinate: either c itself or trunc((2c + p) / 3)
	typedef struct packed {
		logic   div;
		coord_t c;
		coord_t p;
	} slot_t;

	typedef struct packed {
		logic [1:0] cmd;
		slot_t      ax;
		slot_t      ay;
		slot_t      bx;
		slot_t      by;
		coord_t     ex;
		coord_t     ey;
	} res_desc_t;

	typedef struct packed {
		res_desc_t  r0;
		res_desc_t  r1;
		logic [1:0] num;
	} item_desc_t;

	// sign and magnitude of a numerator, ready for the divide
	typedef struct packed {
		logic                 div;
		logic                 neg;
		logic [MAG_WIDTH-1:0] mag;
	} part_t;

	typedef struct packed {
		logic [1:0] cmd;
		part_t      ax;
		part_t      ay;
		part_t      bx;
		part_t      by;
		coord_t     ex;
		coord_t     ey;
	} res_part_t;

	typedef struct packed {
		logic [1:0] cmd;
		coord_t     ax;
		coord_t     ay;
		coord_t     bx;
		coord_t     by;
		coord_t     ex;
		coord_t     ey;
	} res_t;

endpackage

`default_nettype wire

### rtl/outline_points_to_cubic_path_top.sv
// Top level of the outline point to cubic path converter.
// Depends on ocp_pkg, ocp_track, ocp_emit and ocp_div3.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | pt_x pt_y point_kind contour_first
//           |                      | contour_last wrap_x wrap_y
//   out     | out_valid / out_ready| command ax ay bx by ex ey run_last
//
// An accepted point reaches the output register through the input register,
// the descriptor register and the numerator register, in that order.
// One point is taken per cycle while the output does not stall; a point that
// yields two words holds the output port until both words have been taken.
// Reset empties the pipeline and sets the pen and contour start to the origin.
// A stalled output fills any empty stage before in_ready drops.
`default_nettype none

module outline_points_to_cubic_path_top (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire  signed [ocp_pkg::COORD_WIDTH-1:0] pt_x,
	input  wire  signed [ocp_pkg::COORD_WIDTH-1:0] pt_y,
	input  wire  [1:0]                             point_kind,
	input  wire                                    contour_first,
	input  wire                                    contour_last,
	input  wire  signed [ocp_pkg::COORD_WIDTH-1:0] wrap_x,
	input  wire  signed [ocp_pkg::COORD_WIDTH-1:0] wrap_y,
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic [1:0]                             command,
	output logic signed [ocp_pkg::COORD_WIDTH-1:0] ax,
	output logic signed [ocp_pkg::COORD_WIDTH-1:0] ay,
	output logic signed [ocp_pkg::COORD_WIDTH-1:0] bx,
	output logic signed [ocp_pkg::COORD_WIDTH-1:0] by,
	output logic signed [ocp_pkg::COORD_WIDTH-1:0] ex,
	output logic signed [ocp_pkg::COORD_WIDTH-1:0] ey,
	output logic                                   run_last
);

	logic                desc_valid;
	logic                desc_ready;
	ocp_pkg::item_desc_t desc;

	ocp_track u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pt_x          (pt_x),
		.pt_y          (pt_y),
		.point_kind    (point_kind),
		.contour_first (contour_first),
		.contour_last  (contour_last),
		.wrap_x        (wrap_x),
		.wrap_y        (wrap_y),
		.desc_valid    (desc_valid),
		.desc          (desc),
		.desc_ready    (desc_ready)
	);

	ocp_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc       (desc),
		.desc_ready (desc_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.command    (command),
		.ax         (ax),
		.ay         (ay),
		.bx         (bx),
		.by         (by),
		.ex         (ex),
		.ey         (ey),
		.run_last   (run_last)
	);

endmodule

`default_nettype wire

### rtl/ocp_div3.sv
// Signed divide by three, truncating toward zero, by reciprocal multiplication.
// Depends on ocp_pkg for the part and coordinate types and the reciprocal.
`default_nettype none

module ocp_div3 (
	input  ocp_pkg::part_t  part,
	output ocp_pkg::coord_t value
);

	logic [ocp_pkg::MAG_WIDTH+ocp_pkg::DIV_SHIFT-2:0] prod;
	logic [ocp_pkg::COORD_WIDTH-1:0]                  quo;

	assign prod = part.mag * ocp_pkg::DIV_MUL;

	// pass the magnitude through for a plain coordinate
	assign quo = part.div ? prod[ocp_pkg::DIV_SHIFT +: ocp_pkg::COORD_WIDTH]
		: part.mag[ocp_pkg::COORD_WIDTH-1:0];

	assign value = part.neg ? ocp_pkg::coord_t'(~quo + 1'b1) : ocp_pkg::coord_t'(quo);

endmodule

`default_nettype wire

### rtl/ocp_track.sv
// Input register, contour state and the per-point result descriptor stage.
// Depends on ocp_pkg for coordinate, slot and descriptor types.
`default_nettype none

module ocp_track (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [ocp_pkg::COORD_WIDTH-1:0] pt_x,
	input  wire  [ocp_pkg::COORD_WIDTH-1:0] pt_y,
	input  wire  [1:0]                    point_kind,
	input  wire                           contour_first,
	input  wire                           contour_last,
	input  wire  [ocp_pkg::COORD_WIDTH-1:0] wrap_x,
	input  wire  [ocp_pkg::COORD_WIDTH-1:0] wrap_y,
	output logic                          desc_valid,
	output ocp_pkg::item_desc_t           desc,
	input  wire                           desc_ready
);

	function automatic ocp_pkg::coord_t negc(ocp_pkg::coord_t v);
		return ~v + ocp_pkg::coord_t'(1);
	endfunction

	function automatic ocp_pkg::coord_t half_trunc(ocp_pkg::coord_t a, ocp_pkg::coord_t b);
		logic [ocp_pkg::COORD_WIDTH:0] s;
		logic [ocp_pkg::COORD_WIDTH:0] t;
		s = {a[ocp_pkg::COORD_WIDTH-1], a} + {b[ocp_pkg::COORD_WIDTH-1], b};
		// bias a negative sum by one so the shift rounds toward zero
		t = s + {{ocp_pkg::COORD_WIDTH{1'b0}}, s[ocp_pkg::COORD_WIDTH]};
		return t[ocp_pkg::COORD_WIDTH:1];
	endfunction

	function automatic ocp_pkg::coord_t half_floor(ocp_pkg::coord_t a, ocp_pkg::coord_t b);
		logic [ocp_pkg::COORD_WIDTH:0] s;
		s = {a[ocp_pkg::COORD_WIDTH-1], a} + {b[ocp_pkg::COORD_WIDTH-1], b};
		return s[ocp_pkg::COORD_WIDTH:1];
	endfunction

	function automatic ocp_pkg::slot_t direct(ocp_pkg::coord_t v);
		ocp_pkg::slot_t s;
		s.div = 1'b0;
		s.c   = v;
		s.p   = '0;
		return s;
	endfunction

	function automatic ocp_pkg::slot_t third(ocp_pkg::coord_t c, ocp_pkg::coord_t p);
		ocp_pkg::slot_t s;
		s.div = 1'b1;
		s.c   = c;
		s.p   = p;
		return s;
	endfunction

	function automatic ocp_pkg::res_desc_t mk_res(logic [1:0] cmd,
		ocp_pkg::slot_t ax, ocp_pkg::slot_t ay, ocp_pkg::slot_t bx, ocp_pkg::slot_t by,
		ocp_pkg::coord_t ex, ocp_pkg::coord_t ey);
		ocp_pkg::res_desc_t r;
		r.cmd = cmd;
		r.ax  = ax;
		r.ay  = ay;
		r.bx  = bx;
		r.by  = by;
		r.ex  = ex;
		r.ey  = ey;
		return r;
	endfunction

	ocp_pkg::coord_t x_s1, y_s1, wx_s1, wy_s1;
	logic [1:0]      kind_s1;
	logic            first_s1, last_s1, valid_s1;

	ocp_pkg::coord_t p0x_q, p0y_q, p1x_q, p1y_q, p2x_q, p2y_q;
	ocp_pkg::coord_t start_x_q, start_y_q;
	logic [1:0]      cnt_q;

	ocp_pkg::coord_t ny, nwy;
	ocp_pkg::coord_t n0x, n0y, n1x, n1y, n2x, n2y, sx_n, sy_n;
	ocp_pkg::coord_t mid_x, mid_y, qx, qy;
	logic [1:0]      cnt_n;
	ocp_pkg::res_desc_t body_res, end_res, blank;
	logic            body_n, end_n;
	ocp_pkg::item_desc_t desc_n;
	logic            adv2, mv1;

	assign adv2     = !desc_valid || desc_ready;
	assign mv1      = valid_s1 && adv2;
	assign in_ready = !valid_s1 || adv2;

	always_comb begin
		blank = mk_res(ocp_pkg::CMD_CLOSE, direct('0), direct('0), direct('0), direct('0),
			'0, '0);
		ny    = negc(y_s1);
		nwy   = negc(wy_s1);
		n0x   = p0x_q;
		n0y   = p0y_q;
		n1x   = p1x_q;
		n1y   = p1y_q;
		n2x   = p2x_q;
		n2y   = p2y_q;
		sx_n  = start_x_q;
		sy_n  = start_y_q;
		cnt_n = cnt_q;
		mid_x = '0;
		mid_y = '0;
		qx    = x_s1;
		qy    = ny;
		body_res = blank;
		body_n   = 1'b0;
		end_res  = blank;
		end_n    = 1'b0;

		if (first_s1) begin
			if (kind_s1[0]) begin
				sx_n = x_s1;
				sy_n = ny;
			end else begin
				// off-curve opener: start halfway to the contour's last point
				sx_n = half_floor(x_s1, wx_s1);
				sy_n = half_floor(ny, nwy);
			end
			body_res = mk_res(ocp_pkg::CMD_MOVE, direct(sx_n), direct(sy_n),
				direct('0), direct('0), '0, '0);
			body_n = 1'b1;
			n0x    = sx_n;
			n0y    = sy_n;
			cnt_n  = ocp_pkg::PEND_PEN;
		end else if (kind_s1[0]) begin
			case (cnt_q)
				ocp_pkg::PEND_ONE: begin
					body_res = mk_res(ocp_pkg::CMD_CUBIC, third(p1x_q, p0x_q),
						third(p1y_q, p0y_q), third(p1x_q, x_s1), third(p1y_q, ny),
						x_s1, ny);
				end
				ocp_pkg::PEND_TWO: begin
					body_res = mk_res(ocp_pkg::CMD_CUBIC, direct(p1x_q), direct(p1y_q),
						direct(p2x_q), direct(p2y_q), x_s1, ny);
				end
				default: begin
					body_res = mk_res(ocp_pkg::CMD_LINE, direct(x_s1), direct(ny),
						direct('0), direct('0), '0, '0);
				end
			endcase
			body_n = 1'b1;
			n0x    = x_s1;
			n0y    = ny;
			cnt_n  = ocp_pkg::PEND_PEN;
		end else if (kind_s1 == ocp_pkg::KIND_CUBIC) begin
			case (cnt_q)
				ocp_pkg::PEND_TWO: begin
					// third cubic control: end on the midpoint, keep the new one
					mid_x = half_trunc(x_s1, p2x_q);
					mid_y = half_trunc(ny, p2y_q);
					body_res = mk_res(ocp_pkg::CMD_CUBIC, direct(p1x_q), direct(p1y_q),
						direct(p2x_q), direct(p2y_q), mid_x, mid_y);
					body_n = 1'b1;
					n0x    = mid_x;
					n0y    = mid_y;
					n1x    = x_s1;
					n1y    = ny;
					cnt_n  = ocp_pkg::PEND_ONE;
				end
				ocp_pkg::PEND_ONE: begin
					n2x   = x_s1;
					n2y   = ny;
					cnt_n = ocp_pkg::PEND_TWO;
				end
				default: begin
					n1x   = x_s1;
					n1y   = ny;
					cnt_n = ocp_pkg::PEND_ONE;
				end
			endcase
		end else if (cnt_q == ocp_pkg::PEND_ONE || cnt_q == ocp_pkg::PEND_TWO) begin
			// quadratic pair: the held second control wins over the new point
			if (cnt_q == ocp_pkg::PEND_TWO) begin
				qx = p2x_q;
				qy = p2y_q;
			end
			mid_x = half_trunc(p1x_q, qx);
			mid_y = half_trunc(p1y_q, qy);
			body_res = mk_res(ocp_pkg::CMD_CUBIC, third(p1x_q, p0x_q), third(p1y_q, p0y_q),
				third(p1x_q, mid_x), third(p1y_q, mid_y), mid_x, mid_y);
			body_n = 1'b1;
			n0x    = mid_x;
			n0y    = mid_y;
			n1x    = x_s1;
			n1y    = ny;
			cnt_n  = ocp_pkg::PEND_ONE;
		end else begin
			n1x   = x_s1;
			n1y   = ny;
			cnt_n = ocp_pkg::PEND_ONE;
		end

		if (last_s1) begin
			case (cnt_n)
				ocp_pkg::PEND_ONE: begin
					end_res = mk_res(ocp_pkg::CMD_CUBIC, third(n1x, n0x), third(n1y, n0y),
						third(n1x, sx_n), third(n1y, sy_n), sx_n, sy_n);
					n0x = sx_n;
					n0y = sy_n;
				end
				ocp_pkg::PEND_TWO: begin
					end_res = mk_res(ocp_pkg::CMD_CUBIC, direct(n1x), direct(n1y),
						direct(n2x), direct(n2y), sx_n, sy_n);
					n0x = sx_n;
					n0y = sy_n;
				end
				default: begin
					// plain close: hold the pen where it is
					end_res = blank;
				end
			endcase
			end_n = 1'b1;
			cnt_n = ocp_pkg::PEND_PEN;
		end

		if (body_n) begin
			desc_n.r0 = body_res;
			desc_n.r1 = end_res;
		end else begin
			desc_n.r0 = end_res;
			desc_n.r1 = blank;
		end
		desc_n.num = {1'b0, body_n} + {1'b0, end_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			desc_valid <= 1'b0;
			cnt_q      <= ocp_pkg::PEND_PEN;
			p0x_q      <= '0;
			p0y_q      <= '0;
			p1x_q      <= '0;
			p1y_q      <= '0;
			p2x_q      <= '0;
			p2y_q      <= '0;
			start_x_q  <= '0;
			start_y_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				desc_valid <= valid_s1;
			end
			if (mv1) begin
				cnt_q     <= cnt_n;
				p0x_q     <= n0x;
				p0y_q     <= n0y;
				p1x_q     <= n1x;
				p1y_q     <= n1y;
				p2x_q     <= n2x;
				p2y_q     <= n2y;
				start_x_q <= sx_n;
				start_y_q <= sy_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1     <= pt_x;
			y_s1     <= pt_y;
			kind_s1  <= point_kind;
			first_s1 <= contour_first;
			last_s1  <= contour_last;
			wx_s1    <= wrap_x;
			wy_s1    <= wrap_y;
		end
		if (mv1) begin
			desc <= desc_n;
		end
	end

endmodule

`default_nettype wire

### rtl/ocp_emit.sv
// Numerator stage, divide-by-three stage and the two-word output register.
// Depends on ocp_pkg types and on ocp_div3.
`default_nettype none

module ocp_emit (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             desc_valid,
	input  ocp_pkg::item_desc_t             desc,
	output logic                            desc_ready,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [1:0]                      command,
	output logic [ocp_pkg::COORD_WIDTH-1:0] ax,
	output logic [ocp_pkg::COORD_WIDTH-1:0] ay,
	output logic [ocp_pkg::COORD_WIDTH-1:0] bx,
	output logic [ocp_pkg::COORD_WIDTH-1:0] by,
	output logic [ocp_pkg::COORD_WIDTH-1:0] ex,
	output logic [ocp_pkg::COORD_WIDTH-1:0] ey,
	output logic                            run_last
);

	function automatic ocp_pkg::part_t numer(ocp_pkg::slot_t s);
		logic [ocp_pkg::NUM_WIDTH-1:0] n;
		logic [ocp_pkg::NUM_WIDTH-1:0] m;
		ocp_pkg::part_t r;
		if (s.div) begin
			n = {s.c[ocp_pkg::COORD_WIDTH-1], s.c, 1'b0}
				+ {{2{s.p[ocp_pkg::COORD_WIDTH-1]}}, s.p};
		end else begin
			n = {{2{s.c[ocp_pkg::COORD_WIDTH-1]}}, s.c};
		end
		m = n[ocp_pkg::NUM_WIDTH-1] ? ~n + 1'b1 : n;
		r.div = s.div;
		r.neg = n[ocp_pkg::NUM_WIDTH-1];
		r.mag = m[ocp_pkg::MAG_WIDTH-1:0];
		return r;
	endfunction

	function automatic ocp_pkg::res_part_t mk_part(ocp_pkg::res_desc_t d);
		ocp_pkg::res_part_t r;
		r.cmd = d.cmd;
		r.ax  = numer(d.ax);
		r.ay  = numer(d.ay);
		r.bx  = numer(d.bx);
		r.by  = numer(d.by);
		r.ex  = d.ex;
		r.ey  = d.ey;
		return r;
	endfunction

	ocp_pkg::res_part_t r0_s3, r1_s3;
	logic [1:0]         num_s3;
	logic               valid_s3;

	ocp_pkg::part_t  parts [8];
	ocp_pkg::coord_t vals  [8];
	ocp_pkg::res_t   r0_v, r1_v, res0_q, res1_q;
	logic [1:0]      rem_q;
	logic            free, load, take;

	always_comb begin
		parts[0] = r0_s3.ax;
		parts[1] = r0_s3.ay;
		parts[2] = r0_s3.bx;
		parts[3] = r0_s3.by;
		parts[4] = r1_s3.ax;
		parts[5] = r1_s3.ay;
		parts[6] = r1_s3.bx;
		parts[7] = r1_s3.by;
	end

	for (genvar i = 0; i < 8; i++) begin : g_div
		ocp_div3 u_div3 (
			.part  (parts[i]),
			.value (vals[i])
		);
	end

	always_comb begin
		r0_v.cmd = r0_s3.cmd;
		r0_v.ax  = vals[0];
		r0_v.ay  = vals[1];
		r0_v.bx  = vals[2];
		r0_v.by  = vals[3];
		r0_v.ex  = r0_s3.ex;
		r0_v.ey  = r0_s3.ey;
		r1_v.cmd = r1_s3.cmd;
		r1_v.ax  = vals[4];
		r1_v.ay  = vals[5];
		r1_v.bx  = vals[6];
		r1_v.by  = vals[7];
		r1_v.ex  = r1_s3.ex;
		r1_v.ey  = r1_s3.ey;
	end

	assign out_valid  = rem_q != 2'd0;
	assign run_last   = rem_q == 2'd1;
	assign take       = out_valid && out_ready;
	// output register is free when empty or its last word leaves now
	assign free       = (rem_q == 2'd0) || (run_last && out_ready);
	assign load       = valid_s3 && free;
	assign desc_ready = !valid_s3 || load;

	assign command = res0_q.cmd;
	assign ax      = res0_q.ax;
	assign ay      = res0_q.ay;
	assign bx      = res0_q.bx;
	assign by      = res0_q.by;
	assign ex      = res0_q.ex;
	assign ey      = res0_q.ey;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			rem_q    <= 2'd0;
		end else begin
			if (desc_ready) begin
				valid_s3 <= desc_valid;
			end
			if (load) begin
				rem_q <= num_s3;
			end else if (take) begin
				rem_q <= rem_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (desc_valid && desc_ready) begin
			r0_s3  <= mk_part(desc.r0);
			r1_s3  <= mk_part(desc.r1);
			num_s3 <= desc.num;
		end
		if (load) begin
			res0_q <= r0_v;
			res1_q <= r1_v;
		end else if (take) begin
			// advance the second word into the output slot
			res0_q <= res1_q;
		end
	end

endmodule

`default_nettype wire
